// ===== rtl/bbal_pkg.sv =====
package bbal_pkg;

  localparam int unsigned CLS_W = 6;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRCH,
    ST_BACK,
    ST_MARK,
    ST_FCHK,
    ST_FUP,
    ST_FBUD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD     = 2'd1,
    STAT_NOSPACE = 2'd2,
    STAT_NOTHELD = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic taken;
    logic split;
  } flags_t;

  typedef struct packed {
    logic             alloc_bad;
    logic [CLS_W-1:0] want;
    logic             free_bad;
    logic [CLS_W-1:0] free_class;
  } decode_t;

  // floor(log2(v)) for v > 0
  function automatic logic [CLS_W-1:0] flog2_18(input logic [17:0] v);
    logic [CLS_W-1:0] r;
    r = '0;
    for (int i = 0; i < 18; i++) begin
      if (v[i]) r = CLS_W'(i);
    end
    return r;
  endfunction

  function automatic logic [CLS_W-1:0] flog2_13(input logic [12:0] v);
    logic [CLS_W-1:0] r;
    r = '0;
    for (int i = 0; i < 13; i++) begin
      if (v[i]) r = CLS_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/bbal_req_decode.sv =====
// Request decode: size class for an allocate, range and class for a free.
module bbal_req_decode #(
  parameter int unsigned MAX_CLASS    = 16,
  parameter int unsigned MIN_CLASS    = 5,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic [16:0]           request_bytes_i,
  input  logic [11:0]           block_node_i,
  output bbal_pkg::decode_t     dec_o
);

  localparam int unsigned LEVELS = MAX_CLASS - MIN_CLASS + 1;
  localparam int unsigned NODES  = (1 << LEVELS) - 1;

  logic [17:0] total;
  logic [17:0] total_m1;
  logic [33:0] region;
  logic [bbal_pkg::CLS_W-1:0] ceil_c;
  logic [bbal_pkg::CLS_W-1:0] depth;
  logic [12:0] node_p1;

  assign total    = 18'(request_bytes_i) + 18'(HEADER_BYTES);
  assign total_m1 = total - 18'd1;
  assign region   = 34'(1) << MAX_CLASS;
  assign ceil_c   = (total <= 18'd1) ? '0 : bbal_pkg::flog2_18(total_m1) + 1'b1;
  assign node_p1  = 13'(block_node_i) + 13'd1;
  assign depth    = bbal_pkg::flog2_13(node_p1);

  always_comb begin
    dec_o.alloc_bad  = (request_bytes_i == '0) || (34'(total) > region);
    dec_o.want       = (ceil_c < bbal_pkg::CLS_W'(MIN_CLASS)) ?
                       bbal_pkg::CLS_W'(MIN_CLASS) : ceil_c;
    dec_o.free_bad   = (13'(block_node_i) >= 13'(NODES));
    dec_o.free_class = bbal_pkg::CLS_W'(MAX_CLASS) - depth;
  end

endmodule

// ===== rtl/buddy_block_allocator_core.sv =====
// Buddy allocator over a 2^MAX_CLASS byte region. Issue a request by raising
// start_i while busy_o is low; the request is taken on that edge. Exactly one
// result comes back later as a one-cycle done_o strobe with all result ports
// valid in that cycle; the receiver cannot stall it and must capture it then.
// After reset the block sweeps its flag RAM clear, one node per cycle, and
// holds busy_o high until every node has been cleared. An allocate walks the
// tree depth-first (each visited node one read, each backtrack a climb to the
// parent), then marks ancestors split, one per cycle; a free clears the block,
// then reads each buddy and merges upward while the buddy is free. Bad
// requests skip the walk and go straight to the result. The
// single-port-per-direction flag RAM sets the pace.
// Block offsets are byte offsets within the region; the header is counted in
// the block size but not stored.
module buddy_block_allocator_core #(
  parameter int unsigned MAX_CLASS    = 16,
  parameter int unsigned MIN_CLASS    = 5,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [16:0] request_bytes_i,
  input  logic [11:0] block_node_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] node_handle_o,
  output logic [15:0] block_offset_o,
  output logic [4:0]  size_class_o,
  output logic [16:0] used_bytes_o,
  output logic [16:0] spare_bytes_o,
  output logic [11:0] block_count_o
);

  localparam int unsigned LEVELS = MAX_CLASS - MIN_CLASS + 1;
  localparam int unsigned NODES  = (1 << LEVELS) - 1;
  localparam int unsigned NODE_W = LEVELS;
  localparam int unsigned USED_W = MAX_CLASS + 1;
  localparam int unsigned OFF_W  = (MAX_CLASS > 16) ? MAX_CLASS : 16;
  localparam int unsigned CW     = bbal_pkg::CLS_W;

  bbal_pkg::state_e  state_q, state_d;
  bbal_pkg::decode_t dec;

  logic [NODE_W-1:0] idx_q, idx_d;
  logic [CW-1:0]     cur_q, cur_d;
  logic [CW-1:0]     want_q, want_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic [1:0]        stat_q, stat_d;
  logic [11:0]       hand_q, hand_d;
  logic [15:0]       off_q, off_d;
  logic [4:0]        cls_q, cls_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [11:0]       live_q, live_d;

  // flag RAM, one write and one registered read per cycle
  bbal_pkg::flags_t  flag_mem [NODES];
  bbal_pkg::flags_t  rd_q;
  bbal_pkg::flags_t  wr_data;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [NODE_W-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      flag_mem[wr_addr] <= wr_data;
    end
    rd_q <= flag_mem[rd_addr];
  end

  bbal_req_decode #(
    .MAX_CLASS   (MAX_CLASS),
    .MIN_CLASS   (MIN_CLASS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_decode (
    .request_bytes_i(request_bytes_i),
    .block_node_i   (block_node_i),
    .dec_o          (dec)
  );

  // walk helpers
  logic              accept;
  logic              is_root;
  logic              is_left;
  logic              at_want;
  logic              srch_fail;
  logic              srch_hit;
  logic              bud_busy;
  logic [NODE_W-1:0] parent;
  logic [NODE_W-1:0] buddy;
  logic [NODE_W-1:0] left_child;
  logic [NODE_W-1:0] level_base;
  logic [NODE_W-1:0] pos;
  logic [OFF_W-1:0]  off_full;
  logic [USED_W-1:0] blk_size;
  logic [CW-1:0]     depth;

  assign accept     = start_i && (state_q == bbal_pkg::ST_IDLE);
  assign is_root    = (idx_q == '0);
  assign is_left    = idx_q[0];
  assign at_want    = (cur_q == want_q);
  assign srch_fail  = rd_q.taken || (at_want && rd_q.split);
  assign srch_hit   = !rd_q.taken && at_want && !rd_q.split;
  assign bud_busy   = rd_q.taken || rd_q.split;
  assign parent     = (idx_q - 1'b1) >> 1;
  assign buddy      = is_left ? idx_q + 1'b1 : idx_q - 1'b1;
  assign left_child = NODE_W'({idx_q, 1'b1});
  assign depth      = CW'(MAX_CLASS) - cur_q;
  assign level_base = NODE_W'((1 << depth) - 1);
  assign pos        = idx_q - level_base;
  assign off_full   = OFF_W'(pos) << cur_q;
  assign blk_size   = USED_W'(1) << cur_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bbal_pkg::ST_CLEAR: begin
        if (clr_q == NODE_W'(NODES - 1)) state_d = bbal_pkg::ST_IDLE;
      end
      bbal_pkg::ST_IDLE: begin
        if (start_i) begin
          if (operation_i == bbal_pkg::OP_ALLOC) begin
            state_d = dec.alloc_bad ? bbal_pkg::ST_DONE : bbal_pkg::ST_SRCH;
          end else begin
            state_d = dec.free_bad ? bbal_pkg::ST_DONE : bbal_pkg::ST_FCHK;
          end
        end
      end
      bbal_pkg::ST_SRCH: begin
        if (srch_fail) begin
          if (is_root)      state_d = bbal_pkg::ST_DONE;
          else if (is_left) state_d = bbal_pkg::ST_SRCH;
          else              state_d = bbal_pkg::ST_BACK;
        end else if (srch_hit) begin
          state_d = bbal_pkg::ST_MARK;
        end
      end
      bbal_pkg::ST_BACK: begin
        if (is_root)      state_d = bbal_pkg::ST_DONE;
        else if (is_left) state_d = bbal_pkg::ST_SRCH;
      end
      bbal_pkg::ST_MARK: begin
        if (is_root) state_d = bbal_pkg::ST_DONE;
      end
      bbal_pkg::ST_FCHK: begin
        state_d = rd_q.taken ? bbal_pkg::ST_FUP : bbal_pkg::ST_DONE;
      end
      bbal_pkg::ST_FUP: begin
        state_d = is_root ? bbal_pkg::ST_DONE : bbal_pkg::ST_FBUD;
      end
      bbal_pkg::ST_FBUD: begin
        state_d = bud_busy ? bbal_pkg::ST_DONE : bbal_pkg::ST_FUP;
      end
      bbal_pkg::ST_DONE: begin
        state_d = bbal_pkg::ST_IDLE;
      end
      default: state_d = bbal_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    idx_d   = idx_q;
    cur_d   = cur_q;
    want_d  = want_q;
    clr_d   = clr_q;
    stat_d  = stat_q;
    hand_d  = hand_q;
    off_d   = off_q;
    cls_d   = cls_q;
    used_d  = used_q;
    live_d  = live_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = '0;
    rd_addr = idx_q;
    case (state_q)
      bbal_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
      end
      bbal_pkg::ST_IDLE: begin
        if (start_i) begin
          stat_d = bbal_pkg::STAT_OK;
          hand_d = '0;
          off_d  = '0;
          cls_d  = '0;
          if (operation_i == bbal_pkg::OP_ALLOC) begin
            if (dec.alloc_bad) begin
              stat_d = bbal_pkg::STAT_BAD;
            end
            idx_d   = '0;
            cur_d   = CW'(MAX_CLASS);
            want_d  = dec.want;
            rd_addr = '0;
          end else begin
            if (dec.free_bad) begin
              stat_d = bbal_pkg::STAT_BAD;
            end
            idx_d   = NODE_W'(block_node_i);
            cur_d   = dec.free_class;
            rd_addr = NODE_W'(block_node_i);
          end
        end
      end
      bbal_pkg::ST_SRCH, bbal_pkg::ST_BACK: begin
        if (state_q == bbal_pkg::ST_SRCH && srch_hit) begin
          // take it, then mark the path up as split
          wr_en   = 1'b1;
          wr_data = '{taken: 1'b1, split: 1'b0};
          hand_d  = 12'(idx_q);
          off_d   = off_full[15:0];
          cls_d   = 5'(cur_q);
          used_d  = used_q + blk_size;
          live_d  = live_q + 1'b1;
        end else if (state_q == bbal_pkg::ST_SRCH && !srch_fail) begin
          idx_d   = left_child;
          cur_d   = cur_q - 1'b1;
          rd_addr = left_child;
        end else begin
          // backtrack: right sibling if left child, else climb
          if (is_root) begin
            stat_d = bbal_pkg::STAT_NOSPACE;
          end else if (is_left) begin
            idx_d   = idx_q + 1'b1;
            rd_addr = idx_q + 1'b1;
          end else begin
            idx_d = parent;
            cur_d = cur_q + 1'b1;
          end
        end
      end
      bbal_pkg::ST_MARK: begin
        if (!is_root) begin
          wr_en   = 1'b1;
          wr_addr = parent;
          wr_data = '{taken: 1'b0, split: 1'b1};
          idx_d   = parent;
        end
      end
      bbal_pkg::ST_FCHK: begin
        if (!rd_q.taken) begin
          stat_d = bbal_pkg::STAT_NOTHELD;
        end else begin
          wr_en   = 1'b1;
          wr_data = '{taken: 1'b0, split: rd_q.split};
          cls_d   = 5'(cur_q);
          used_d  = (used_q >= blk_size) ? used_q - blk_size : '0;
          if (live_q != '0) live_d = live_q - 1'b1;
        end
      end
      bbal_pkg::ST_FUP: begin
        rd_addr = buddy;
      end
      bbal_pkg::ST_FBUD: begin
        if (!bud_busy) begin
          wr_en   = 1'b1;
          wr_addr = parent;
          wr_data = '{taken: 1'b0, split: 1'b0};
          idx_d   = parent;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbal_pkg::ST_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
      live_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      live_q  <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    want_q <= want_d;
    stat_q <= stat_d;
    hand_q <= hand_d;
    off_q  <= off_d;
    cls_q  <= cls_d;
  end

  assign busy_o         = (state_q != bbal_pkg::ST_IDLE);
  assign done_o         = (state_q == bbal_pkg::ST_DONE);
  assign status_o       = stat_q;
  assign node_handle_o  = hand_q;
  assign block_offset_o = off_q;
  assign size_class_o   = cls_q;
  assign used_bytes_o   = 17'(used_q);
  assign spare_bytes_o  = 17'((USED_W'(1) << MAX_CLASS) - used_q);
  assign block_count_o  = live_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("transfer taken but block not busy");

  a_ok_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bbal_pkg::STAT_OK) |-> (size_class_o != '0))
    else $error("ok result without a size class");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bbal_pkg::STAT_OK) |->
      (node_handle_o == '0 && block_offset_o == '0 && size_class_o == '0))
    else $error("failed request reports a block");

endmodule
